// ===== rtl/core/aat_pkg.sv =====
// Shared types and constants for the box transform core.
// No dependencies; imported by the interfaces' users and every module.
package aat_pkg;

	typedef logic signed [31:0] q16_t;
	typedef logic signed [63:0] prod_t;
	typedef logic signed [65:0] acc_t;
	typedef logic signed [49:0] wide_t;

	localparam int unsigned RegCount = 6;
	localparam int unsigned FracBits = 16;

	typedef enum logic [2:0] {
		REG_X_XY = 3'd0,
		REG_X_ZT = 3'd1,
		REG_Y_XY = 3'd2,
		REG_Y_ZT = 3'd3,
		REG_Z_XY = 3'd4,
		REG_Z_ZT = 3'd5
	} reg_idx_t;

	localparam logic [63:0] OneQ16   = 64'h0000_0000_0001_0000;
	localparam logic [63:0] OneQ16Hi = 64'h0001_0000_0000_0000;

	typedef struct packed {
		q16_t t;
		q16_t cz;
		q16_t cy;
		q16_t cx;
	} coef_t;

	typedef struct packed {
		q16_t z;
		q16_t y;
		q16_t x;
	} vec_t;

	typedef struct packed {
		q16_t mn;
		q16_t mx;
	} span_t;

	function automatic q16_t sat_q16(input wide_t v);
		q16_t r;
		if (v > 50'sd2147483647) begin
			r = 32'sh7fff_ffff;
		end else if (v < -50'sd2147483648) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/aat_box_if.sv =====
// Input channel: one box beat (min and max corners, signed Q16.16).
// No dependencies.
interface aat_box_if;
	logic valid;
	logic ready;
	logic signed [31:0] box_min_x;
	logic signed [31:0] box_min_y;
	logic signed [31:0] box_min_z;
	logic signed [31:0] box_max_x;
	logic signed [31:0] box_max_y;
	logic signed [31:0] box_max_z;

	modport source (
		output valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
		input ready
	);
	modport sink (
		input valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
		output ready
	);
endinterface

// ===== rtl/core/aat_res_if.sv =====
// Output channel: one transformed box beat (saturated Q16.16).
// No dependencies.
interface aat_res_if;
	logic valid;
	logic ready;
	logic signed [31:0] out_min_x;
	logic signed [31:0] out_min_y;
	logic signed [31:0] out_min_z;
	logic signed [31:0] out_max_x;
	logic signed [31:0] out_max_y;
	logic signed [31:0] out_max_z;

	modport source (
		output valid, out_min_x, out_min_y, out_min_z, out_max_x, out_max_y, out_max_z,
		input ready
	);
	modport sink (
		input valid, out_min_x, out_min_y, out_min_z, out_max_x, out_max_y, out_max_z,
		output ready
	);
endinterface

// ===== rtl/core/aat_core_top.sv =====
// Top level of the axis-aligned box transform core.
// Depends on aat_pkg, aat_box_if, aat_res_if and aat_axis.
//
// One box beat is accepted per clock while the core is not stalled, and its
// transformed bounds are presented through three registers: an input
// register that orders each min/max pair, a product register behind the 18
// 32x32 multipliers, and the result register after the sum, floor and
// saturation. All stages advance together whenever the result register is
// empty or being taken, so a full-rate stream sees no bubbles.
// The 3x4 matrix registers reset to identity and should be written only
// while no beat is in flight; writes to an index past the last are dropped.
module aabb_affine_transform_core import aat_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [63:0] cfg_data,
	aat_box_if.sink     box,
	aat_res_if.source   res
);

	logic [63:0] coef_q [RegCount];
	logic        en;
	logic        vld_s1, vld_s2, out_vld_q;
	vec_t        lo_s1, hi_s1;
	span_t       span_x, span_y, span_z;
	span_t       out_x_q, out_y_q, out_z_q;
	coef_t       coef_x, coef_y, coef_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q[REG_X_XY] <= OneQ16;
			coef_q[REG_X_ZT] <= '0;
			coef_q[REG_Y_XY] <= OneQ16Hi;
			coef_q[REG_Y_ZT] <= '0;
			coef_q[REG_Z_XY] <= '0;
			coef_q[REG_Z_ZT] <= OneQ16;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_X_XY: coef_q[REG_X_XY] <= cfg_data;
				REG_X_ZT: coef_q[REG_X_ZT] <= cfg_data;
				REG_Y_XY: coef_q[REG_Y_XY] <= cfg_data;
				REG_Y_ZT: coef_q[REG_Y_ZT] <= cfg_data;
				REG_Z_XY: coef_q[REG_Z_XY] <= cfg_data;
				REG_Z_ZT: coef_q[REG_Z_ZT] <= cfg_data;
				default: ;
			endcase
		end
	end

	assign coef_x = {coef_q[REG_X_ZT], coef_q[REG_X_XY]};
	assign coef_y = {coef_q[REG_Y_ZT], coef_q[REG_Y_XY]};
	assign coef_z = {coef_q[REG_Z_ZT], coef_q[REG_Z_XY]};

	assign en        = !out_vld_q || res.ready;
	assign box.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			vld_s1    <= box.valid;
			vld_s2    <= vld_s1;
			out_vld_q <= vld_s2;
		end
	end

	// order each coordinate pair so an inverted box behaves like its swap
	always_ff @(posedge clk) begin
		if (en) begin
			lo_s1.x <= (box.box_min_x <= box.box_max_x) ? box.box_min_x : box.box_max_x;
			hi_s1.x <= (box.box_min_x <= box.box_max_x) ? box.box_max_x : box.box_min_x;
			lo_s1.y <= (box.box_min_y <= box.box_max_y) ? box.box_min_y : box.box_max_y;
			hi_s1.y <= (box.box_min_y <= box.box_max_y) ? box.box_max_y : box.box_min_y;
			lo_s1.z <= (box.box_min_z <= box.box_max_z) ? box.box_min_z : box.box_max_z;
			hi_s1.z <= (box.box_min_z <= box.box_max_z) ? box.box_max_z : box.box_min_z;
		end
	end

	aat_axis u_axis_x (.clk(clk), .en(en), .coef(coef_x), .lo(lo_s1), .hi(hi_s1), .span(span_x));
	aat_axis u_axis_y (.clk(clk), .en(en), .coef(coef_y), .lo(lo_s1), .hi(hi_s1), .span(span_y));
	aat_axis u_axis_z (.clk(clk), .en(en), .coef(coef_z), .lo(lo_s1), .hi(hi_s1), .span(span_z));

	always_ff @(posedge clk) begin
		if (en) begin
			out_x_q <= span_x;
			out_y_q <= span_y;
			out_z_q <= span_z;
		end
	end

	assign res.valid     = out_vld_q;
	assign res.out_min_x = out_x_q.mn;
	assign res.out_min_y = out_y_q.mn;
	assign res.out_min_z = out_z_q.mn;
	assign res.out_max_x = out_x_q.mx;
	assign res.out_max_y = out_y_q.mx;
	assign res.out_max_z = out_z_q.mx;

endmodule

// ===== rtl/core/aat_axis.sv =====
// One output axis: picks the extreme corner per term, multiplies, registers
// the products, then sums them with the translation, floors and saturates. Uses aat_pkg.
module aat_axis import aat_pkg::*; (
	input  logic  clk,
	input  logic  en,
	input  coef_t coef,
	input  vec_t  lo,
	input  vec_t  hi,
	output span_t span
);

	// for a negative coefficient the larger coordinate gives the smaller term
	q16_t  op_min_x, op_min_y, op_min_z, op_max_x, op_max_y, op_max_z;
	prod_t pmin_x_s2, pmin_y_s2, pmin_z_s2, pmax_x_s2, pmax_y_s2, pmax_z_s2;
	acc_t  sum_min, sum_max, t_ext;

	assign op_min_x = coef.cx[31] ? hi.x : lo.x;
	assign op_max_x = coef.cx[31] ? lo.x : hi.x;
	assign op_min_y = coef.cy[31] ? hi.y : lo.y;
	assign op_max_y = coef.cy[31] ? lo.y : hi.y;
	assign op_min_z = coef.cz[31] ? hi.z : lo.z;
	assign op_max_z = coef.cz[31] ? lo.z : hi.z;

	always_ff @(posedge clk) begin
		if (en) begin
			pmin_x_s2 <= coef.cx * op_min_x;
			pmax_x_s2 <= coef.cx * op_max_x;
			pmin_y_s2 <= coef.cy * op_min_y;
			pmax_y_s2 <= coef.cy * op_max_y;
			pmin_z_s2 <= coef.cz * op_min_z;
			pmax_z_s2 <= coef.cz * op_max_z;
		end
	end

	assign t_ext   = acc_t'(coef.t) <<< FracBits;
	assign sum_min = acc_t'(pmin_x_s2) + acc_t'(pmin_y_s2) + acc_t'(pmin_z_s2) + t_ext;
	assign sum_max = acc_t'(pmax_x_s2) + acc_t'(pmax_y_s2) + acc_t'(pmax_z_s2) + t_ext;

	assign span.mn = sat_q16(sum_min[65:16]);
	assign span.mx = sat_q16(sum_max[65:16]);

endmodule

// ===== sim/aabb_affine_transform_core_test.sv =====
// Self-checking bench for aabb_affine_transform_core: directed and random boxes
// under several matrix settings, checked against an exact integer transform.
// Depends on aat_pkg, aat_box_if, aat_res_if and the core RTL.
`timescale 1ns / 1ps

module aabb_affine_transform_core_test;
	import aat_pkg::*;

	typedef struct packed {
		q16_t min_x;
		q16_t min_y;
		q16_t min_z;
		q16_t max_x;
		q16_t max_y;
		q16_t max_z;
	} aabb_t;

	typedef struct packed {
		logic  typed;
		aabb_t stim;
		aabb_t want;
	} vector_t;

	localparam q16_t QMax = 32'sh7fff_ffff;
	localparam q16_t QMin = 32'sh8000_0000;
	localparam logic [2:0] IdxSpare0 = 3'd6;
	localparam logic [2:0] IdxSpare1 = 3'd7;
	localparam int NumPhases = 8;
	localparam int BeatsPerPhase = 50;

	// typed rows hold the bounds expected under the reset (identity) matrix
	localparam vector_t DirectedRows [12] = '{
		'{1'b1, {6{32'h0}}, {6{32'h0}}},
		'{1'b1, {QMin, QMin, QMin, QMax, QMax, QMax}, {QMin, QMin, QMin, QMax, QMax, QMax}},
		'{1'b1, {QMax, QMax, QMax, QMin, QMin, QMin}, {QMin, QMin, QMin, QMax, QMax, QMax}},
		'{1'b1, {6{32'hffff_ffff}}, {6{32'hffff_ffff}}},
		'{1'b1, {32'sd1, -32'sd2, 32'sd3, 32'sd4, 32'sd5, -32'sd6},
			{32'sd1, -32'sd2, -32'sd6, 32'sd4, 32'sd5, 32'sd3}},
		'{1'b1, {{3{32'h5555_5555}}, {3{32'haaaa_aaaa}}},
			{{3{32'haaaa_aaaa}}, {3{32'h5555_5555}}}},
		'{1'b1, {{3{32'h0001_0000}}, {3{32'h0001_8000}}},
			{{3{32'h0001_0000}}, {3{32'h0001_8000}}}},
		'{1'b1, {6{32'h1234_5678}}, {6{32'h1234_5678}}},
		'{1'b0, {32'sd1, -32'sd1, 32'sd3, -32'sd3, 32'sd5, 32'sh7fff}, {6{32'h0}}},
		'{1'b0, {32'h0000_8001, 32'hffff_7fff, 32'h0000_0001,
			32'hffff_ffff, 32'h0001_0001, 32'h8000_0001}, {6{32'h0}}},
		'{1'b0, {QMin, 32'h0, QMax, QMax, 32'h0, QMin}, {6{32'h0}}},
		'{1'b0, {32'hdead_beef, 32'h0bad_f00d, 32'h1234_5678,
			32'hcafe_f00d, 32'h7654_3210, 32'h8765_4321}, {6{32'h0}}}
	};

	// {xy, zt} written to every axis: saturation high, saturation low, halves for rounding
	localparam logic [127:0] DirSettings [3] = '{
		{64'h7fff_ffff_7fff_ffff, 64'h7fff_ffff_7fff_ffff},
		{64'h8000_0000_8000_0000, 64'h8000_0000_8000_0000},
		{64'hffff_8000_0000_8000, 64'hffff_ffff_0000_4000}
	};

	string field_names [6] = '{"min_x", "min_y", "min_z", "max_x", "max_y", "max_z"};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_idx;
	logic [63:0] cfg_data;
	bit          steady = 1'b0;
	int          mismatches = 0;
	logic [63:0] matrix [RegCount];
	aabb_t       bounds_q [$];

	aat_box_if box_ch ();
	aat_res_if res_ch ();

	aabb_affine_transform_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.box      (box_ch),
		.res      (res_ch)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [63:0] reset_value(input int unsigned idx);
		case (idx)
			REG_X_XY: return OneQ16;
			REG_Y_XY: return OneQ16Hi;
			REG_Z_ZT: return OneQ16;
			default: return 64'h0;
		endcase
	endfunction

	function automatic q16_t clamp_q16(input logic signed [67:0] v);
		if (v > 68'sd2147483647) begin
			return QMax;
		end else if (v < -68'sd2147483648) begin
			return QMin;
		end
		return v[31:0];
	endfunction

	// exact sum of the three products, floored by the shift, plus translation
	function automatic aabb_t transform_box(input aabb_t b);
		q16_t lo [3];
		q16_t hi [3];
		q16_t mn [3];
		q16_t mx [3];
		logic signed [67:0] cx, cy, cz, t, px, py, pz, v, low_v, high_v;
		int a, c;
		lo = '{b.min_x, b.min_y, b.min_z};
		hi = '{b.max_x, b.max_y, b.max_z};
		for (a = 0; a < 3; a++) begin
			cx = $signed(matrix[2*a][31:0]);
			cy = $signed(matrix[2*a][63:32]);
			cz = $signed(matrix[2*a+1][31:0]);
			t  = $signed(matrix[2*a+1][63:32]);
			for (c = 0; c < 8; c++) begin
				px = c[0] ? hi[0] : lo[0];
				py = c[1] ? hi[1] : lo[1];
				pz = c[2] ? hi[2] : lo[2];
				v = ((cx * px + cy * py + cz * pz) >>> FracBits) + t;
				if (c == 0 || v < low_v) low_v = v;
				if (c == 0 || v > high_v) high_v = v;
			end
			mn[a] = clamp_q16(low_v);
			mx[a] = clamp_q16(high_v);
		end
		return {mn[0], mn[1], mn[2], mx[0], mx[1], mx[2]};
	endfunction

	function automatic q16_t rand_coord();
		case ($urandom_range(0, 9))
			0: return $urandom_range(0, 1) ? QMax : QMin;
			1, 2, 3, 4, 5: return $urandom_range(0, 32'h7f_ffff) - 32'h40_0000;
			default: return $urandom();
		endcase
	endfunction

	function automatic q16_t rand_coef_half();
		case ($urandom_range(0, 9))
			0: return QMax;
			1: return QMin;
			2: return 32'h0;
			3: return OneQ16[31:0];
			4, 5, 6, 7: return $urandom_range(0, 32'h7_ffff) - 32'h4_0000;
			default: return $urandom();
		endcase
	endfunction

	task automatic cfg_write(input logic [2:0] idx, input logic [63:0] val);
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= val;
		if (idx < RegCount) matrix[idx] = val;
		@(posedge clk);
	endtask

	task automatic cfg_end();
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_box(input aabb_t b, input logic typed, input aabb_t want);
		@(negedge clk);
		while (!steady && $urandom_range(0, 99) < 20) begin
			box_ch.valid <= 1'b0;
			@(negedge clk);
		end
		box_ch.valid     <= 1'b1;
		box_ch.box_min_x <= b.min_x;
		box_ch.box_min_y <= b.min_y;
		box_ch.box_min_z <= b.min_z;
		box_ch.box_max_x <= b.max_x;
		box_ch.box_max_y <= b.max_y;
		box_ch.box_max_z <= b.max_z;
		do @(posedge clk); while (!box_ch.ready);
		bounds_q.push_back(typed ? want : transform_box(b));
	endtask

	task automatic wait_drained();
		@(negedge clk);
		box_ch.valid <= 1'b0;
		while (bounds_q.size() != 0) @(posedge clk);
	endtask

	task automatic check_beat(input aabb_t got);
		aabb_t want;
		int i;
		if (bounds_q.size() == 0) begin
			$display("%t unexpected beat: %h", $time, got);
			mismatches++;
		end else begin
			want = bounds_q.pop_front();
			for (i = 0; i < 6; i++) begin
				if (got[191 - 32*i -: 32] !== want[191 - 32*i -: 32]) begin
					$display("%t mismatch %s: expected %h, actual %h", $time,
						field_names[i], want[191 - 32*i -: 32], got[191 - 32*i -: 32]);
					mismatches++;
				end
			end
		end
	endtask

	always @(negedge clk) res_ch.ready <= steady || ($urandom_range(0, 99) >= 20);

	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready) begin
			check_beat({res_ch.out_min_x, res_ch.out_min_y, res_ch.out_min_z,
				res_ch.out_max_x, res_ch.out_max_y, res_ch.out_max_z});
		end
	end

	initial begin
		int i, s, p, n;
		aabb_t b;
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_idx          = 3'd0;
		cfg_data         = 64'h0;
		box_ch.valid     = 1'b0;
		box_ch.box_min_x = '0;
		box_ch.box_min_y = '0;
		box_ch.box_min_z = '0;
		box_ch.box_max_x = '0;
		box_ch.box_max_y = '0;
		box_ch.box_max_z = '0;
		res_ch.ready     = 1'b0;
		for (i = 0; i < RegCount; i++) matrix[i] = reset_value(i);
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// writes past the last register must leave the identity matrix alone
		cfg_write(IdxSpare0, '1);
		cfg_write(IdxSpare1, '1);
		cfg_end();
		for (i = 0; i < 12; i++)
			send_box(DirectedRows[i].stim, DirectedRows[i].typed, DirectedRows[i].want);

		for (s = 0; s < 3; s++) begin
			wait_drained();
			for (i = 0; i < 3; i++) begin
				cfg_write(3'(2*i), DirSettings[s][127:64]);
				cfg_write(3'(2*i + 1), DirSettings[s][63:0]);
			end
			cfg_end();
			for (i = 0; i < 12; i++)
				if (!DirectedRows[i].typed) send_box(DirectedRows[i].stim, 1'b0, '0);
		end

		for (p = 0; p < NumPhases; p++) begin
			wait_drained();
			for (i = 0; i < RegCount; i++)
				cfg_write(3'(i), p == 0 ? reset_value(i) : {rand_coef_half(), rand_coef_half()});
			if ($urandom_range(0, 3) == 0)
				cfg_write(3'($urandom_range(IdxSpare0, IdxSpare1)), {$urandom(), $urandom()});
			cfg_end();
			steady = (p == 3 || p == 4);
			for (n = 0; n < BeatsPerPhase; n++) begin
				b = {rand_coord(), rand_coord(), rand_coord(),
					rand_coord(), rand_coord(), rand_coord()};
				send_box(b, 1'b0, '0);
			end
		end
		steady = 1'b0;

		wait_drained();
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin
		#400us;
		$display("status: fail");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/aat_pkg.sv
rtl/core/aat_box_if.sv
rtl/core/aat_res_if.sv
rtl/core/aat_axis.sv
rtl/core/aat_core_top.sv
sim/aabb_affine_transform_core_test.sv
